### design/bta_pkg.sv
// package for the buddy tree allocator: sizes, node codes, opcodes, fsm states
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;
  localparam int HEAP_LOG2 = 20;
  localparam int MIN_BLOCK_LOG2 = 12;
  localparam int NODE_COUNT = 511;
  localparam int IDX_W = $clog2(NODE_COUNT + 1);
  localparam int LAYER_W = 6;
  localparam logic [IDX_W:0] NODE_LIMIT = (IDX_W + 1)'(NODE_COUNT);

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_USED    = 2'd1,
    ST_SPLIT   = 2'd2,
    ST_INVALID = 2'd3
  } node_t;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_CHK, S_SPLIT, S_DESC, S_DESC_CHK,
    S_SIB, S_SIB_CHK, S_CLEAR, S_DONE
  } fsm_t;

  // memory request from the sequencer
  typedef struct packed {
    logic             rd;
    logic [IDX_W-1:0] raddr;
    logic             wr;
    logic [IDX_W-1:0] waddr;
    node_t            wdata;
  } mem_req_t;
endpackage
`default_nettype wire

### design/buddy_tree_allocator.sv
// top level: buddy allocator sequencer over the node state memory
// An item takes a variable number of cycles, with at most one node access per cycle.
// Allocate scans the tree nodes layer by layer, from the target layer up to
// the root, over at most all 511 nodes, then writes two nodes per split level
// and one for the used block. Free walks down the tree level by level and
// merges back up while the sibling is free. Clear rewrites every node, one per
// cycle. After reset the same clearing pass runs while no item is accepted.
// One item is worked at a time; the result waits in an output register and
// the input stalls until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module buddy_tree_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] free_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic [31:0]      block_address
);
  localparam int IW = bta_pkg::IDX_W;
  localparam int LW = bta_pkg::LAYER_W;

  bta_pkg::fsm_t state, state_next;
  bta_pkg::mem_req_t req;
  bta_pkg::node_t rdata;

  logic [31:0] heap_base;
  logic [IW:0] idx, idx_next;       // current node (wide to reach limit)
  logic [IW:0] lend, lend_next;     // end of scanned layer
  logic [LW-1:0] layer, layer_next; // scanned layer
  logic [LW-1:0] tgt, tgt_next;     // target layer
  logic [32:0] off, off_next;       // free offset remaining
  logic [32:0] bsize, bsize_next;   // current block size
  logic        rst_clr, rst_clr_next;
  logic        res_status, res_status_next;
  logic [31:0] res_addr, res_addr_next;
  logic        out_load;

  bta_node_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  // size to target layer
  logic [5:0] lg;
  logic [32:0] req_m1;
  logic size_ok;
  always_comb begin
    req_m1 = {1'b0, request_size} - 33'd1;
    lg = 6'd0;
    for (int b = 0; b < 32; b++) begin
      if (req_m1[b]) lg = 6'(b + 1);
    end
    if (lg < 6'(bta_pkg::MIN_BLOCK_LOG2)) lg = 6'(bta_pkg::MIN_BLOCK_LOG2);
    size_ok = (request_size != 32'd0) &&
              ({1'b0, request_size} <= (33'd1 << bta_pkg::HEAP_LOG2)) &&
              (lg <= 6'(bta_pkg::HEAP_LOG2));
  end

  // layer start and end, leaf of split path
  logic [IW:0] lay_start, lay_end;
  logic [40:0] leaf_p1;
  logic [40:0] tgt_first;
  always_comb begin
    lay_start = (IW + 1)'((41'd1 << layer) - 41'd1);
    lay_end = ((41'd1 << (layer + 6'd1)) - 41'd1) > 41'(bta_pkg::NODE_COUNT)
              ? bta_pkg::NODE_LIMIT
              : (IW + 1)'((41'd1 << (layer + 6'd1)) - 41'd1);
    leaf_p1 = (41'(idx) + 41'd1) << (tgt - layer);
    tgt_first = (41'd1 << tgt) - 41'd1;
  end

  logic in_take;
  assign in_take = in_valid && !in_stall;
  assign in_stall = (state != bta_pkg::S_IDLE) || out_valid;
  assign out_load = (state == bta_pkg::S_DONE);

  // sequencer
  always_comb begin
    state_next = state;
    idx_next = idx; lend_next = lend; layer_next = layer; tgt_next = tgt;
    off_next = off; bsize_next = bsize;
    rst_clr_next = rst_clr;
    res_status_next = res_status; res_addr_next = res_addr;
    req = '0;
    req.wdata = bta_pkg::ST_INVALID;
    unique case (state)
      bta_pkg::S_IDLE: begin
        if (in_take) begin
          res_status_next = 1'b1;
          res_addr_next = 32'd0;
          case (opcode)
            bta_pkg::OP_ALLOC: begin
              if (size_ok) begin
                tgt_next = 6'(bta_pkg::HEAP_LOG2) - lg;
                layer_next = 6'(bta_pkg::HEAP_LOG2) - lg;
                state_next = bta_pkg::S_SCAN;
                idx_next = '1;
              end else begin
                state_next = bta_pkg::S_DONE;
              end
            end
            bta_pkg::OP_FREE: begin
              if (free_address >= heap_base && {1'b0, free_address} <
                  {1'b0, heap_base} + (33'd1 << bta_pkg::HEAP_LOG2)) begin
                off_next = {1'b0, free_address} - {1'b0, heap_base};
                bsize_next = 33'd1 << bta_pkg::HEAP_LOG2;
                idx_next = '0;
                state_next = bta_pkg::S_DESC;
              end else begin
                state_next = bta_pkg::S_DONE;
              end
            end
            bta_pkg::OP_CLEAR: begin
              idx_next = '0;
              res_status_next = 1'b0;
              state_next = bta_pkg::S_CLEAR;
            end
            default: state_next = bta_pkg::S_DONE;
          endcase
        end
      end
      bta_pkg::S_SCAN: begin
        // idx all ones marks start of a new layer
        if (idx == '1) begin
          idx_next = lay_start;
          lend_next = lay_end;
        end else if (idx >= lend) begin
          if (layer == '0) begin
            state_next = bta_pkg::S_DONE;
          end else begin
            layer_next = layer - 6'd1;
            idx_next = '1;
          end
        end else begin
          req.rd = 1'b1;
          req.raddr = idx[IW-1:0];
          state_next = bta_pkg::S_SCAN_CHK;
        end
      end
      bta_pkg::S_SCAN_CHK: begin
        if (rdata == bta_pkg::ST_FREE &&
            !(layer < tgt && leaf_p1 >= 41'(bta_pkg::NODE_COUNT))) begin
          // lend[0] now selects the split write, parent first
          lend_next[0] = 1'b0;
          state_next = bta_pkg::S_SPLIT;
        end else begin
          idx_next = idx + 1'b1;
          state_next = bta_pkg::S_SCAN;
        end
      end
      bta_pkg::S_SPLIT: begin
        // one split level per pass: mark split, right child free
        req.wr = 1'b1;
        req.waddr = idx[IW-1:0];
        if (layer == tgt) begin
          req.wdata = bta_pkg::ST_USED;
          res_status_next = 1'b0;
          res_addr_next = heap_base + 32'((41'(idx) - tgt_first)
                          << (6'(bta_pkg::HEAP_LOG2) - tgt));
          state_next = bta_pkg::S_DONE;
        end else if (!lend[0]) begin
          req.wdata = bta_pkg::ST_SPLIT;
          lend_next[0] = 1'b1;
        end else begin
          req.waddr = IW'({idx, 1'b0} + 2'd2);
          req.wdata = bta_pkg::ST_FREE;
          lend_next[0] = 1'b0;
          idx_next = (IW + 1)'({idx, 1'b0} + 2'd1);
          layer_next = layer + 6'd1;
        end
      end
      bta_pkg::S_DESC: begin
        if (idx >= bta_pkg::NODE_LIMIT) begin
          state_next = bta_pkg::S_DONE;
        end else begin
          req.rd = 1'b1;
          req.raddr = idx[IW-1:0];
          state_next = bta_pkg::S_DESC_CHK;
        end
      end
      bta_pkg::S_DESC_CHK: begin
        if (rdata == bta_pkg::ST_SPLIT) begin
          bsize_next = bsize >> 1;
          if (off < (bsize >> 1)) begin
            idx_next = (IW + 1)'({idx, 1'b0} + 2'd1);
          end else begin
            off_next = off - (bsize >> 1);
            idx_next = (IW + 1)'({idx, 1'b0} + 2'd2);
          end
          state_next = bta_pkg::S_DESC;
        end else if (rdata == bta_pkg::ST_USED && off == '0) begin
          req.wr = 1'b1;
          req.waddr = idx[IW-1:0];
          req.wdata = bta_pkg::ST_FREE;
          res_status_next = 1'b0;
          state_next = (idx == '0) ? bta_pkg::S_DONE : bta_pkg::S_SIB;
        end else begin
          state_next = bta_pkg::S_DONE;
        end
      end
      bta_pkg::S_SIB: begin
        // lend holds the sibling index here
        lend_next = idx[0] ? idx + 1'b1 : idx - 1'b1;
        if ((idx[0] ? idx + 1'b1 : idx - 1'b1) >= bta_pkg::NODE_LIMIT) begin
          state_next = bta_pkg::S_DONE;
        end else begin
          req.rd = 1'b1;
          req.raddr = IW'(idx[0] ? idx + 1'b1 : idx - 1'b1);
          state_next = bta_pkg::S_SIB_CHK;
          off_next[0] = 1'b0;
        end
      end
      bta_pkg::S_SIB_CHK: begin
        if (rdata != bta_pkg::ST_FREE && !off[0]) begin
          state_next = bta_pkg::S_DONE;
        end else if (!off[0]) begin
          // writes in order: node invalid, sibling invalid, parent free
          req.wr = 1'b1;
          req.waddr = idx[IW-1:0];
          req.wdata = bta_pkg::ST_INVALID;
          off_next[0] = 1'b1;
        end else if (!off[1]) begin
          req.wr = 1'b1;
          req.waddr = lend[IW-1:0];
          req.wdata = bta_pkg::ST_INVALID;
          off_next[1] = 1'b1;
        end else begin
          req.wr = 1'b1;
          idx_next = (idx - 1'b1) >> 1;
          req.waddr = IW'((idx - 1'b1) >> 1);
          req.wdata = bta_pkg::ST_FREE;
          off_next[1:0] = 2'b00;
          state_next = (((idx - 1'b1) >> 1) == '0) ? bta_pkg::S_DONE
                                                  : bta_pkg::S_SIB;
        end
      end
      bta_pkg::S_CLEAR: begin
        req.wr = 1'b1;
        req.waddr = idx[IW-1:0];
        req.wdata = (idx == '0) ? bta_pkg::ST_FREE : bta_pkg::ST_INVALID;
        idx_next = idx + 1'b1;
        if (idx + 1'b1 >= bta_pkg::NODE_LIMIT) begin
          state_next = rst_clr ? bta_pkg::S_IDLE : bta_pkg::S_DONE;
          rst_clr_next = 1'b0;
        end
      end
      bta_pkg::S_DONE: state_next = bta_pkg::S_IDLE;
      default: state_next = bta_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bta_pkg::S_CLEAR;
      idx <= '0;
      rst_clr <= 1'b1;
      off <= '0;
      lend <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      rst_clr <= rst_clr_next;
      off <= off_next;
      lend <= lend_next;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    layer <= layer_next;
    tgt <= tgt_next;
    bsize <= bsize_next;
    res_status <= res_status_next;
    res_addr <= res_addr_next;
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (cfg_we) begin
      heap_base <= cfg_wdata;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= res_status;
      block_address <= res_addr;
    end
  end

  // assertions
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != bta_pkg::S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    (state == bta_pkg::S_DONE) |=> (state == bta_pkg::S_IDLE))
    else $error("done not single cycle");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (block_address == 32'd0))
    else $error("error beat carries an address");
  a_no_rdwr: assert property (@(posedge clk) disable iff (rst)
    !(req.rd && req.wr))
    else $error("read and write in one cycle");
endmodule
`default_nettype wire

### design/bta_node_ram.sv
// node state memory, one read and one write port, registered read
`timescale 1ns / 1ps
`default_nettype none
module bta_node_ram (
  input  wire logic              clk,
  input  wire bta_pkg::mem_req_t req,
  output bta_pkg::node_t         rdata
);
  bta_pkg::node_t mem [bta_pkg::NODE_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

### tb/buddy_tree_allocator_tb.sv
// testbench for the buddy tree allocator: directed and random allocate/free/clear/unknown-opcode beats
`timescale 1ns / 1ps
module buddy_tree_allocator_tb;
  localparam int WATCHDOG_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 1200;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = bta_pkg::OP_ALLOC;
  logic [31:0] request_size = '0;
  logic [31:0] free_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [31:0] block_address;

  typedef struct packed {
    logic        status;
    logic [31:0] addr;
  } alloc_result_t;

  // predicted allocator state
  bta_pkg::node_t tree_model [bta_pkg::NODE_COUNT];
  logic [31:0]    base_model;
  alloc_result_t  pending_results [$];
  logic [31:0]    live_blocks [$];

  int  mismatch_count = 0;
  int  idle_cycles = 0;
  bit  quiet_mode = 1'b0;
  bit  timed_out = 1'b0;

  always #5 clk = ~clk;

  buddy_tree_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .request_size(request_size), .free_address(free_address),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .block_address(block_address)
  );

  function automatic bta_pkg::node_t tree_get(longint idx);
    if (idx >= bta_pkg::NODE_COUNT) return bta_pkg::ST_INVALID;
    return tree_model[idx];
  endfunction

  function automatic void tree_put(longint idx, bta_pkg::node_t v);
    if (idx < bta_pkg::NODE_COUNT) tree_model[idx] = v;
  endfunction

  function automatic void tree_reset_model();
    foreach (tree_model[i]) tree_model[i] = bta_pkg::ST_INVALID;
    tree_model[0] = bta_pkg::ST_FREE;
  endfunction

  // allocate at tree layer t, returns offset or -1
  function automatic longint tree_alloc(int t);
    longint first, last, leaf, j;
    for (int l = t; l >= 0; l--) begin
      first = (longint'(1) << l) - 1;
      last = (longint'(1) << (l + 1)) - 1;
      if (last > bta_pkg::NODE_COUNT) last = bta_pkg::NODE_COUNT;
      for (longint i = first; i < last; i++) begin
        if (tree_get(i) != bta_pkg::ST_FREE) continue;
        leaf = ((i + 1) << (t - l)) - 1;
        if (l < t && leaf + 1 >= bta_pkg::NODE_COUNT) continue;
        j = i;
        for (int k = l; k < t; k++) begin
          tree_put(j, bta_pkg::ST_SPLIT);
          tree_put(2 * j + 1, bta_pkg::ST_FREE);
          tree_put(2 * j + 2, bta_pkg::ST_FREE);
          j = 2 * j + 1;
        end
        tree_put(j, bta_pkg::ST_USED);
        return (j - ((longint'(1) << t) - 1)) << (bta_pkg::HEAP_LOG2 - t);
      end
    end
    return -1;
  endfunction

  function automatic bit tree_release(logic [31:0] addr);
    longint heap_bytes, off, span, i, parent, sib;
    heap_bytes = longint'(1) << bta_pkg::HEAP_LOG2;
    span = heap_bytes;
    i = 0;
    if (addr < base_model || longint'(addr) >= longint'(base_model) + heap_bytes)
      return 0;
    off = longint'(addr) - longint'(base_model);
    while (tree_get(i) == bta_pkg::ST_SPLIT) begin
      span = span >> 1;
      if (off < span) i = 2 * i + 1;
      else begin
        off -= span;
        i = 2 * i + 2;
      end
    end
    if (tree_get(i) != bta_pkg::ST_USED || off != 0) return 0;
    tree_put(i, bta_pkg::ST_FREE);
    while (i != 0) begin
      parent = (i - 1) / 2;
      sib = i[0] ? i + 1 : i - 1;
      if (tree_get(sib) != bta_pkg::ST_FREE) break;
      tree_put(i, bta_pkg::ST_INVALID);
      tree_put(sib, bta_pkg::ST_INVALID);
      tree_put(parent, bta_pkg::ST_FREE);
      i = parent;
    end
    return 1;
  endfunction

  // expected result of one beat
  function automatic alloc_result_t predict_beat(logic [1:0] op, logic [31:0] rsize,
                                                 logic [31:0] faddr);
    alloc_result_t r;
    longint off;
    int lg;
    r.status = 1'b1;
    r.addr = '0;
    if (op == bta_pkg::OP_ALLOC) begin
      if (rsize != 0 && longint'(rsize) <= (longint'(1) << bta_pkg::HEAP_LOG2)) begin
        lg = 0;
        while ((longint'(1) << lg) < longint'(rsize)) lg++;
        if (lg < bta_pkg::MIN_BLOCK_LOG2) lg = bta_pkg::MIN_BLOCK_LOG2;
        if (lg <= bta_pkg::HEAP_LOG2) begin
          off = tree_alloc(bta_pkg::HEAP_LOG2 - lg);
          if (off >= 0) begin
            r.status = 1'b0;
            r.addr = base_model + off[31:0];
            live_blocks.push_back(r.addr);
          end
        end
      end
    end else if (op == bta_pkg::OP_FREE) begin
      if (tree_release(faddr)) r.status = 1'b0;
    end else if (op == bta_pkg::OP_CLEAR) begin
      tree_reset_model();
      live_blocks.delete();
      r.status = 1'b0;
    end
    return r;
  endfunction

  // send one beat and record its prediction; valid stays up until the next idle
  task automatic send_beat(logic [1:0] op, logic [31:0] rsize, logic [31:0] faddr);
    while (!quiet_mode && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    request_size <= rsize;
    free_address <= faddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_beat(op, rsize, faddr));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] value);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_model = value;
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 10);
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat status=%0d", status);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status || block_address !== exp_r.addr) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: status exp %0d got %0d, addr exp %h got %h",
                     exp_r.status, status, exp_r.addr, block_address);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or taken result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] a;
    send_beat(bta_pkg::OP_ALLOC, 32'd0, '0);
    send_beat(bta_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_beat(bta_pkg::OP_ALLOC, 32'h0010_0001, '0);
    send_beat(bta_pkg::OP_ALLOC, 32'h0010_0000, '0);
    send_beat(bta_pkg::OP_ALLOC, 32'd1, '0);
    send_beat(bta_pkg::OP_FREE, '0, base_model);
    send_beat(bta_pkg::OP_ALLOC, 32'd1, '0);
    send_beat(bta_pkg::OP_ALLOC, 32'd4096, '0);
    send_beat(bta_pkg::OP_ALLOC, 32'd4097, '0);
    send_beat(bta_pkg::OP_ALLOC, 32'h0008_0000, '0);
    send_beat(bta_pkg::OP_FREE, '0, base_model + 32'd4096);
    send_beat(bta_pkg::OP_FREE, '0, base_model + 32'd4096);
    send_beat(bta_pkg::OP_FREE, '0, base_model + 32'd100);
    send_beat(bta_pkg::OP_FREE, '0, base_model - 32'd1);
    send_beat(bta_pkg::OP_FREE, '0, base_model + 32'h0010_0000);
    send_beat(bta_pkg::OP_FREE, '0, 32'hFFFF_FFFF);
    send_beat(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(bta_pkg::OP_CLEAR, '0, '0);
    for (int i = 0; i < 5; i++) begin
      while (live_blocks.size() != 0) begin
        a = live_blocks.pop_front();
        send_beat(bta_pkg::OP_FREE, '0, a);
      end
    end
  endtask

  // random beats, mostly allocates and valid frees of live blocks
  task automatic test_random(int beats);
    int pick;
    int idx;
    logic [31:0] rsize;
    logic [31:0] faddr;
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        case ($urandom_range(3))
          0: rsize = $urandom_range(4096, 1);
          1: rsize = $urandom_range(65536, 1);
          2: rsize = 32'd1 << $urandom_range(20, 0);
          default: rsize = $urandom();
        endcase
        send_beat(bta_pkg::OP_ALLOC, rsize, $urandom());
      end else if (pick < 85 && live_blocks.size() != 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        faddr = live_blocks[idx];
        live_blocks.delete(idx);
        send_beat(bta_pkg::OP_FREE, $urandom(), faddr);
      end else if (pick < 94) begin
        faddr = ($urandom_range(1) != 0) ? $urandom()
                                         : base_model + $urandom_range(32'h10_0000);
        send_beat(bta_pkg::OP_FREE, $urandom(), faddr);
      end else if (pick < 97) begin
        send_beat(bta_pkg::OP_CLEAR, $urandom(), $urandom());
      end else begin
        send_beat(OP_UNKNOWN, $urandom(), $urandom());
      end
    end
  endtask

  task automatic test_no_idling(int beats);
    quiet_mode = 1'b1;
    test_random(beats);
    quiet_mode = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_drain();
    test_random(50);
  endtask

  initial begin
    tree_reset_model();
    base_model = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(400);
    write_base(32'hFFFF_FFFF);
    test_directed();
    test_random(200);
    write_base(32'hFFF8_0000);
    test_no_idling(200);
    test_drain_pause();
    write_base($urandom());
    test_random(200);
    write_base(32'h0000_0000);
    test_random(50);
    wait_drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
